// ===== rtl/core/ctlt_pkg.sv =====
// ============================================================================
// ctlt_pkg
// Shared types and constants for the command line tokenizer.
// ============================================================================
package ctlt_pkg;

   localparam int unsigned MAX_ARG_LEN = 64;
   localparam int unsigned MAX_ARGS    = 16;
   localparam int unsigned NAME_LEN    = 32;

   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   // Limits in the widths of the counters that they are compared with.
   localparam logic [5:0] NAME_KEEP = 6'(NAME_LEN - 1);
   localparam logic [5:0] ARG_KEEP  = 6'(MAX_ARG_LEN - 1);
   localparam logic [4:0] ARG_LIMIT = 5'(MAX_ARGS);

   typedef enum logic [1:0] {
      PH_NAME = 2'd0,
      PH_GAP  = 2'd1,
      PH_ARG  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      K_NAME_CHAR = 3'd0,
      K_NAME_END  = 3'd1,
      K_ARG_CHAR  = 3'd2,
      K_ARG_END   = 3'd3,
      K_DONE      = 3'd4
   } kind_type;

   // Parser state carried from one character to the next.
   typedef struct packed {
      phase_type  phase;
      logic       quote_open;
      logic       dropping;
      logic [5:0] char_count;
      logic [4:0] arg_number;
      logic       overflowed;
   } parse_state_type;

   // One result item.
   typedef struct packed {
      kind_type   out_kind;
      logic [3:0] arg_index;
      logic [5:0] position;
      logic [7:0] out_char;
      logic       missing_quote;
      logic [4:0] arg_count;
      logic       too_many;
      logic       last;
   } result_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:      PH_NAME,
      quote_open: 1'b0,
      dropping:   1'b0,
      char_count: 6'd0,
      arg_number: 5'd0,
      overflowed: 1'b0
   };

endpackage

// ===== rtl/core/command_line_tokenizer.sv =====
// ============================================================================
// command_line_tokenizer
// Splits a command line, one character per item, into name and arguments.
// ============================================================================
// Usage:
// The request channel (req_valid, req_ready, req_ch) takes one character
// per item; a zero character ends the line. The response channel gives
// name characters, the name end, argument characters, argument ends and a
// final line-done item, each with rsp_last set on the final item caused by
// one character. A character causes zero, one or two items.
// The first item caused by an accepted character passes the input register
// and then the result queue before it appears.
// Throughput: one character per cycle while each causes at most one
// item and the receiver takes items; the four-entry result queue drains
// one item per cycle, so the two items of one character leave in turn.
// A stalled receiver fills the queue, after which req_ready drops once
// fewer than two free entries remain.
// Reset (synchronous, active high) empties the queue and the input
// register and returns the parser to the start of a command name.
// ============================================================================
module command_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_out_kind,
   output logic [3:0] rsp_arg_index,
   output logic [5:0] rsp_position,
   output logic [7:0] rsp_out_char,
   output logic       rsp_missing_quote,
   output logic [4:0] rsp_arg_count,
   output logic       rsp_too_many,
   output logic       rsp_last
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] ch_ff;

   // Parser state, updated when a character is processed.
   ctlt_pkg::parse_state_type state_ff, state_in, state_nxt;

   ctlt_pkg::result_type result0, result1, rsp_item;
   logic [1:0]           result_num;
   logic                 room_two;
   logic                 step_go;
   logic                 req_take;

   // The held character is processed once the queue can take both of
   // its possible items; the input register refills in the same cycle.
   assign step_go   = in_valid_ff && room_two;
   assign req_ready = !in_valid_ff || step_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (in_valid_ff && !step_go);
      state_in    = step_go ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ctlt_pkg::STATE_CLEAR;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff <= req_ch;
      end
   end

   ctlt_step u_step (
      .ch         (ch_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_nxt),
      .result0    (result0),
      .result1    (result1),
      .result_num (result_num)
   );

   ctlt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_num  (step_go ? result_num : 2'd0),
      .push0     (result0),
      .push1     (result1),
      .room_two  (room_two),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_out_kind      = rsp_item.out_kind;
   assign rsp_arg_index     = rsp_item.arg_index;
   assign rsp_position      = rsp_item.position;
   assign rsp_out_char      = rsp_item.out_char;
   assign rsp_missing_quote = rsp_item.missing_quote;
   assign rsp_arg_count     = rsp_item.arg_count;
   assign rsp_too_many      = rsp_item.too_many;
   assign rsp_last          = rsp_item.last;

endmodule

// ===== rtl/core/ctlt_step.sv =====
// ============================================================================
// ctlt_step
// Combinational parse of one character: next state and up to two results.
// ============================================================================
module ctlt_step (
   input  logic [7:0]                ch,
   input  ctlt_pkg::parse_state_type state_cur,
   output ctlt_pkg::parse_state_type state_nxt,
   output ctlt_pkg::result_type      result0,
   output ctlt_pkg::result_type      result1,
   output logic [1:0]                result_num
);

   always_comb begin
      ctlt_pkg::parse_state_type st;
      ctlt_pkg::result_type      res [2];
      logic [1:0]                n;
      logic                      end_now;
      logic                      end_mq;
      logic                      live;
      logic                      is_end;

      st      = state_cur;
      res[0]  = '0;
      res[1]  = '0;
      n       = 2'd0;
      end_now = 1'b0;
      end_mq  = 1'b0;
      is_end  = (ch == ctlt_pkg::CH_END);

      if (st.phase == ctlt_pkg::PH_NAME) begin
         if (is_end || ch == ctlt_pkg::CH_SPACE) begin
            res[0].out_kind = ctlt_pkg::K_NAME_END;
            res[0].position = st.char_count;
            n = 2'd1;
            if (!is_end) begin
               st.phase      = ctlt_pkg::PH_GAP;
               st.char_count = 6'd0;
            end
         end else if (st.char_count < ctlt_pkg::NAME_KEEP) begin
            res[0].out_kind = ctlt_pkg::K_NAME_CHAR;
            res[0].position = st.char_count;
            res[0].out_char = ch;
            n = 2'd1;
            st.char_count = st.char_count + 6'd1;
         end
      end else if (st.phase == ctlt_pkg::PH_GAP) begin
         if (!is_end && ch != ctlt_pkg::CH_SPACE) begin
            st.phase      = ctlt_pkg::PH_ARG;
            st.quote_open = 1'b0;
            st.dropping   = 1'b0;
            st.char_count = 6'd0;
            if (st.arg_number >= ctlt_pkg::ARG_LIMIT) begin
               st.overflowed = 1'b1;
            end
         end
      end

      live = (st.arg_number < ctlt_pkg::ARG_LIMIT);

      if (st.phase == ctlt_pkg::PH_ARG) begin
         if (is_end) begin
            end_now = 1'b1;
            end_mq  = st.quote_open;
         end else if (st.dropping) begin
            if (ch == ctlt_pkg::CH_SPACE && !st.quote_open) begin
               end_now = 1'b1;
            end else if (ch == ctlt_pkg::CH_QUOTE && st.quote_open) begin
               st.quote_open = 1'b0;
               st.dropping   = 1'b0;
            end
         end else if (ch == ctlt_pkg::CH_QUOTE) begin
            st.quote_open = !st.quote_open;
            end_now       = !st.quote_open;
         end else if (ch == ctlt_pkg::CH_SPACE && !st.quote_open) begin
            end_now = 1'b1;
         end else if (st.char_count >= ctlt_pkg::ARG_KEEP) begin
            st.dropping = 1'b1;
         end else begin
            if (live) begin
               res[0].out_kind  = ctlt_pkg::K_ARG_CHAR;
               res[0].arg_index = st.arg_number[3:0];
               res[0].position  = st.char_count;
               res[0].out_char  = ch;
               n = 2'd1;
            end
            st.char_count = st.char_count + 6'd1;
         end
      end

      // Argument end; an argument beyond the kept number ends silently.
      if (end_now) begin
         if (live) begin
            res[0].out_kind      = ctlt_pkg::K_ARG_END;
            res[0].arg_index     = st.arg_number[3:0];
            res[0].position      = st.char_count;
            res[0].missing_quote = end_mq;
            n = 2'd1;
            st.arg_number = st.arg_number + 5'd1;
         end
         st.phase      = ctlt_pkg::PH_GAP;
         st.quote_open = 1'b0;
         st.dropping   = 1'b0;
         st.char_count = 6'd0;
      end

      if (is_end) begin
         res[n[0]]           = '0;
         res[n[0]].out_kind  = ctlt_pkg::K_DONE;
         res[n[0]].arg_count = st.arg_number;
         res[n[0]].too_many  = st.overflowed;
         n  = n + 2'd1;
         st = ctlt_pkg::STATE_CLEAR;
      end

      if (n == 2'd2) begin
         res[1].last = 1'b1;
      end else if (n == 2'd1) begin
         res[0].last = 1'b1;
      end

      state_nxt  = st;
      result0    = res[0];
      result1    = res[1];
      result_num = n;
   end

endmodule

// ===== rtl/core/ctlt_rsp_queue.sv =====
// ============================================================================
// ctlt_rsp_queue
// Four-entry result queue taking up to two items per cycle, giving one.
// ============================================================================
module ctlt_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_num,
   input  ctlt_pkg::result_type push0,
   input  ctlt_pkg::result_type push1,
   output logic                 room_two,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ctlt_pkg::result_type out_item
);

   ctlt_pkg::result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_num;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_num} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

endmodule

// ===== tb/sv/command_line_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// command_line_tokenizer_tb
// Self-checking testbench for the command line tokenizer.
// ============================================================================
// A short table of hand-picked characters comes first. It covers the empty
// line, extreme character codes, quotes in the name, quoted and empty
// arguments, and a line that ends inside an open quote. After it come
// randomly built command lines. Most of these are well formed, with long
// names, full arguments, quoted text and more arguments than the block
// keeps. A few are raw noise. Every accepted character is run through a
// behavioural tokenizer in this file, and each item that the block returns
// is compared field by field with the oldest expected item. The random part
// runs in several phases of sender idling and receiver stalling. It also
// includes one long receiver hold-off that fills the block.
// ============================================================================
module command_line_tokenizer_tb;

   // Fixed run figures.
   localparam int unsigned RANDOM_ITEMS = 1700;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_AT = RANDOM_ITEMS / 8;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned REPORT_LIMIT = 40;
   localparam int unsigned TIMEOUT_NS = 1_000_000;
   localparam int unsigned DIRECTED_ROWS = 24;

   localparam ctlt_pkg::result_type NO_RESULT = '0;

   // Every input starts at a known value. Reset is held from time zero.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_out_kind;
   logic [3:0] rsp_arg_index;
   logic [5:0] rsp_position;
   logic [7:0] rsp_out_char;
   logic       rsp_missing_quote;
   logic [4:0] rsp_arg_count;
   logic       rsp_too_many;
   logic       rsp_last;

   command_line_tokenizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_arg_index     (rsp_arg_index),
      .rsp_position      (rsp_position),
      .rsp_out_char      (rsp_out_char),
      .rsp_missing_quote (rsp_missing_quote),
      .rsp_arg_count     (rsp_arg_count),
      .rsp_too_many      (rsp_too_many),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Behavioural tokenizer
   // -------------------------------------------------------------------------
   // The counters are kept as plain integers. The masking to the port widths
   // happens only when an expected item is formed.
   typedef struct {
      ctlt_pkg::phase_type phase;
      bit                  quote_open;
      bit                  dropping;
      int unsigned         char_count;
      int unsigned         arg_number;
      bit                  overflowed;
   } line_state_type;

   line_state_type       line_state;
   ctlt_pkg::result_type pending_results[$];

   function automatic void restart_line();
      line_state.phase      = ctlt_pkg::PH_NAME;
      line_state.quote_open = 1'b0;
      line_state.dropping   = 1'b0;
      line_state.char_count = 0;
      line_state.arg_number = 0;
      line_state.overflowed = 1'b0;
   endfunction

   function automatic void add_result(ctlt_pkg::kind_type kind, int unsigned index,
                                      int unsigned pos, logic [7:0] ch, bit open_quote,
                                      int unsigned count, bit over);
      ctlt_pkg::result_type r;
      r.out_kind      = kind;
      r.arg_index     = 4'(index);
      r.position      = 6'(pos);
      r.out_char      = ch;
      r.missing_quote = open_quote;
      r.arg_count     = 5'(count);
      r.too_many      = over;
      r.last          = 1'b0;
      pending_results.push_back(r);
   endfunction

   // An argument beyond the kept number ends silently. Its end is not reported.
   function automatic void close_argument(bit open_quote);
      if (line_state.arg_number < ctlt_pkg::MAX_ARGS) begin
         add_result(ctlt_pkg::K_ARG_END, line_state.arg_number, line_state.char_count,
                    8'h00, open_quote, 0, 1'b0);
         line_state.arg_number++;
      end
      line_state.phase      = ctlt_pkg::PH_GAP;
      line_state.quote_open = 1'b0;
      line_state.dropping   = 1'b0;
      line_state.char_count = 0;
   endfunction

   // Appends the items that one character causes and marks the final one.
   function automatic void tokenize_char(logic [7:0] c);
      int unsigned          first;
      bit                   live;
      ctlt_pkg::result_type final_item;
      first = pending_results.size();

      if (line_state.phase == ctlt_pkg::PH_NAME) begin
         if (c == ctlt_pkg::CH_END) begin
            add_result(ctlt_pkg::K_NAME_END, 0, line_state.char_count, 8'h00, 1'b0, 0,
                       1'b0);
         end else if (c == ctlt_pkg::CH_SPACE) begin
            add_result(ctlt_pkg::K_NAME_END, 0, line_state.char_count, 8'h00, 1'b0, 0,
                       1'b0);
            line_state.phase      = ctlt_pkg::PH_GAP;
            line_state.char_count = 0;
         end else if (line_state.char_count < ctlt_pkg::NAME_LEN - 1) begin
            // A quote in the name is stored like any other character.
            add_result(ctlt_pkg::K_NAME_CHAR, 0, line_state.char_count, c, 1'b0, 0, 1'b0);
            line_state.char_count++;
         end
      end else if (line_state.phase == ctlt_pkg::PH_GAP) begin
         if (c != ctlt_pkg::CH_END && c != ctlt_pkg::CH_SPACE) begin
            line_state.phase      = ctlt_pkg::PH_ARG;
            line_state.quote_open = 1'b0;
            line_state.dropping   = 1'b0;
            line_state.char_count = 0;
            if (line_state.arg_number >= ctlt_pkg::MAX_ARGS) begin
               line_state.overflowed = 1'b1;
            end
         end
      end

      // The character that opens an argument is parsed as part of it in the
      // same step.
      if (line_state.phase == ctlt_pkg::PH_ARG) begin
         live = line_state.arg_number < ctlt_pkg::MAX_ARGS;
         if (c == ctlt_pkg::CH_END) begin
            close_argument(line_state.quote_open);
         end else if (line_state.dropping) begin
            // A full argument only looks for its end, or for a closing quote.
            if (c == ctlt_pkg::CH_SPACE && !line_state.quote_open) begin
               close_argument(1'b0);
            end else if (c == ctlt_pkg::CH_QUOTE && line_state.quote_open) begin
               line_state.quote_open = 1'b0;
               line_state.dropping   = 1'b0;
            end
         end else if (c == ctlt_pkg::CH_QUOTE) begin
            line_state.quote_open = !line_state.quote_open;
            if (!line_state.quote_open) begin
               close_argument(1'b0);
            end
         end else if (c == ctlt_pkg::CH_SPACE && !line_state.quote_open) begin
            close_argument(1'b0);
         end else if (line_state.char_count >= ctlt_pkg::MAX_ARG_LEN - 1) begin
            line_state.dropping = 1'b1;
         end else begin
            if (live) begin
               add_result(ctlt_pkg::K_ARG_CHAR, line_state.arg_number,
                          line_state.char_count, c, 1'b0, 0, 1'b0);
            end
            line_state.char_count++;
         end
      end

      if (c == ctlt_pkg::CH_END) begin
         add_result(ctlt_pkg::K_DONE, 0, 0, 8'h00, 1'b0, line_state.arg_number,
                    line_state.overflowed);
         restart_line();
      end

      if (pending_results.size() > first) begin
         final_item = pending_results.pop_back();
         final_item.last = 1'b1;
         pending_results.push_back(final_item);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Directed table
   // -------------------------------------------------------------------------
   // Rows with a typed count carry their expected items in full. These are
   // the cases that are plain at a glance. All other rows rely on the
   // behavioural tokenizer.
   typedef struct {
      logic [7:0]           ch;
      int unsigned          typed_count;
      ctlt_pkg::result_type first_result;
      ctlt_pkg::result_type second_result;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // An empty line straight after reset.
      '{ctlt_pkg::CH_END, 2,
        '{ctlt_pkg::K_NAME_END, 4'd0, 6'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},
        '{ctlt_pkg::K_DONE, 4'd0, 6'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
      // The highest character code opens a name.
      '{8'hFF, 1,
        '{ctlt_pkg::K_NAME_CHAR, 4'd0, 6'd0, 8'hFF, 1'b0, 5'd0, 1'b0, 1'b1}, NO_RESULT},
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},   // a quote inside the name is kept
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},   // ends the name
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},   // skipped
      '{8'h78,              0, NO_RESULT, NO_RESULT},
      '{8'h01,              0, NO_RESULT, NO_RESULT},   // lowest non-zero code
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},   // quoted argument with a space
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},
      '{8'h79,              0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},   // the closing quote ends it
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},   // an empty pair of quotes
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_QUOTE, 0, NO_RESULT, NO_RESULT},   // a quote left open
      '{8'h7A,              0, NO_RESULT, NO_RESULT},
      // The line ends inside the open quote of the fourth argument.
      '{ctlt_pkg::CH_END, 2,
        '{ctlt_pkg::K_ARG_END, 4'd3, 6'd1, 8'h00, 1'b1, 5'd0, 1'b0, 1'b0},
        '{ctlt_pkg::K_DONE, 4'd0, 6'd0, 8'h00, 1'b0, 5'd4, 1'b0, 1'b1}},
      '{8'h61,              0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_SPACE, 0, NO_RESULT, NO_RESULT},
      '{8'h62,              0, NO_RESULT, NO_RESULT},
      '{ctlt_pkg::CH_END,   0, NO_RESULT, NO_RESULT},   // the line ends inside an argument
      '{8'h71,              0, NO_RESULT, NO_RESULT},
      // The line ends inside a one-character name.
      '{ctlt_pkg::CH_END, 2,
        '{ctlt_pkg::K_NAME_END, 4'd0, 6'd1, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},
        '{ctlt_pkg::K_DONE, 4'd0, 6'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}}
   };

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned random_items = 0;
   logic [7:0]  line_chars[$];

   // Offers one character and waits for it to be accepted. Valid is held
   // high from one item to the next unless an idle cycle falls in between.
   task automatic offer_char(logic [7:0] c, int unsigned typed_count,
                             ctlt_pkg::result_type first_result,
                             ctlt_pkg::result_type second_result);
      int unsigned first;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (!req_ready);
      first = pending_results.size();
      tokenize_char(c);
      if (typed_count > 0) begin
         // The tokenizer still has to follow the line. The items it forms
         // give way to the typed ones, however.
         while (pending_results.size() > first) begin
            void'(pending_results.pop_back());
         end
         pending_results.push_back(first_result);
         if (typed_count > 1) begin
            pending_results.push_back(second_result);
         end
      end
   endtask

   // Sender goes quiet until every expected item has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Ordinary argument or name character: never zero, space or quote.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      case ($urandom_range(9))
         0:       c = 8'($urandom_range(255, 128));
         1:       c = 8'($urandom_range(31, 1));
         default: c = 8'($urandom_range(126, 35));
      endcase
      return c;
   endfunction

   // Noise is heavy on the characters that steer the parser.
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0:       c = ctlt_pkg::CH_SPACE;
         1:       c = ctlt_pkg::CH_QUOTE;
         2:       c = ($urandom_range(15) == 0) ? ctlt_pkg::CH_END : 8'($urandom_range(255));
         default: c = 8'($urandom_range(255));
      endcase
      return c;
   endfunction

   // Builds one command line. Most lines are well formed. Some have long
   // names, full arguments or more arguments than are kept. A few are
   // noise or leave a quote open.
   task automatic build_line();
      int unsigned name_len;
      int unsigned arg_total;
      int unsigned len;
      bit          quoted;
      line_chars.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(30, 1)) line_chars.push_back(noise_char());
      end else begin
         name_len = ($urandom_range(7) == 0) ? $urandom_range(40, 28) : $urandom_range(8);
         repeat (name_len) begin
            line_chars.push_back(($urandom_range(11) == 0) ? ctlt_pkg::CH_QUOTE
                                                           : plain_char());
         end
         arg_total = ($urandom_range(11) == 0) ? $urandom_range(20, 14) : $urandom_range(5);
         repeat (arg_total) begin
            repeat ($urandom_range(3, 1)) line_chars.push_back(ctlt_pkg::CH_SPACE);
            len    = ($urandom_range(9) == 0) ? $urandom_range(72, 58) : $urandom_range(8, 1);
            quoted = $urandom_range(1);
            if (quoted) begin
               line_chars.push_back(ctlt_pkg::CH_QUOTE);
            end
            repeat (len) begin
               case ($urandom_range(19))
                  0:       line_chars.push_back(ctlt_pkg::CH_QUOTE);
                  1:       line_chars.push_back(quoted ? ctlt_pkg::CH_SPACE : plain_char());
                  default: line_chars.push_back(plain_char());
               endcase
            end
            if (quoted && $urandom_range(4) != 0) begin
               line_chars.push_back(ctlt_pkg::CH_QUOTE);
            end
         end
         repeat ($urandom_range(2)) line_chars.push_back(ctlt_pkg::CH_SPACE);
      end
      line_chars.push_back(ctlt_pkg::CH_END);
   endtask

   // -------------------------------------------------------------------------
   // Receiver
   // -------------------------------------------------------------------------
   // Once the random part is under way, the receiver holds off for a long
   // stretch. The sender meanwhile runs without gaps, so the result queue
   // fills and req_ready has to drop.
   initial begin
      int unsigned hold_left;
      bit          held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && random_items >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   int unsigned fail_count = 0;

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         if (fail_count < REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      ctlt_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("%0t: unexpected item, expected none, got kind %0d char %0d",
                        $time, rsp_out_kind, rsp_out_char);
            end
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_kind", want.out_kind, rsp_out_kind);
            check_field("arg_index", want.arg_index, rsp_arg_index);
            check_field("position", want.position, rsp_position);
            check_field("out_char", want.out_char, rsp_out_char);
            check_field("missing_quote", want.missing_quote, rsp_missing_quote);
            check_field("arg_count", want.arg_count, rsp_arg_count);
            check_field("too_many", want.too_many, rsp_too_many);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   // The four random phases are: no idling, a mostly idle sender, a mostly
   // stalling receiver, and light idling on both sides.
   int unsigned send_idle_by_phase [4] = '{0, 85, 0, 25};
   int unsigned recv_stall_by_phase [4] = '{0, 0, 85, 25};

   initial begin
      restart_line();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 25;
      recv_stall_pct = 25;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_char(directed_rows[i].ch, directed_rows[i].typed_count,
                    directed_rows[i].first_result, directed_rows[i].second_result);
      end
      pause_until_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_idle_by_phase[p];
         recv_stall_pct = recv_stall_by_phase[p];
         while (random_items < (p + 1) * RANDOM_ITEMS / 4) begin
            build_line();
            foreach (line_chars[k]) begin
               offer_char(line_chars[k], 0, NO_RESULT, NO_RESULT);
               random_items++;
            end
         end
         // Between phases, the sender waits for every expected item to be returned.
         pause_until_drained();
      end

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("command_line_tokenizer test passed");
      end else begin
         $display("command_line_tokenizer test failed");
      end
      $finish;
   end

   // The run ends here if the block stops answering.
   initial begin
      #(TIMEOUT_NS);
      $display("command_line_tokenizer test failed");
      $finish;
   end

endmodule
